[hw/rtl/amd_pkg.sv]
// Shared types, constants and iteration steps for the affine matrix decomposer.
// Used by amd_rowlen, amd_quat and affine_matrix_decompose; no dependencies.

package amd_pkg;

	// Field widths
	localparam int MAT_W   = 24;
	localparam int NRM_W   = 32;
	localparam int QUAT_W  = 18;

	// Pipeline lengths of the iterative units
	localparam int LEN_STEPS  = 24;	// root bits of a row length
	localparam int NRM_STEPS  = 31;	// quotient bits of a normalized element
	localparam int ROOT_STEPS = 32;	// root bits of the branch radicand
	localparam int QDIV_STEPS = 17;	// quotient bits of a quaternion component

	// One in Q.30, wide enough for the branch radicand arithmetic
	localparam logic signed [34:0] NRM_ONE = 35'sd1073741824;
	// One in Q1.16
	localparam logic [16:0] QUAT_ONE = 17'd65536;

	// Which quaternion component carries the square root
	typedef enum logic [1:0] {
		BR_W = 2'd0,
		BR_X = 2'd1,
		BR_Y = 2'd2,
		BR_Z = 2'd3
	} branch_t;

	typedef logic signed [NRM_W-1:0] nrm_t;

	// Items that ride along the pipeline with the math
	typedef struct packed {
		logic signed [MAT_W-1:0] pos_x;
		logic signed [MAT_W-1:0] pos_y;
		logic signed [MAT_W-1:0] pos_z;
		logic [MAT_W-1:0]        scale_x;
		logic [MAT_W-1:0]        scale_y;
		logic [MAT_W-1:0]        scale_z;
		logic                    zero;
	} side_t;

	// Digit-by-digit square root state
	typedef struct packed {
		logic [33:0] rem;
		logic [31:0] root;
	} sqrt_t;

	// Restoring divider step result
	typedef struct packed {
		logic [31:0] rem;
		logic        qbit;
	} div_t;

	// One root bit per call: bring down two radicand bits, try 4*root+1
	function automatic sqrt_t sqrt_step(sqrt_t cur, logic [1:0] pair);
		logic [35:0] trial;
		logic [35:0] sub;
		sqrt_t       nxt;
		trial = {cur.rem, pair};
		sub   = {2'b00, cur.root, 2'b01};
		if (trial >= sub) begin
			nxt.rem  = 34'(trial - sub);
			nxt.root = {cur.root[30:0], 1'b1};
		end else begin
			nxt.rem  = trial[33:0];
			nxt.root = {cur.root[30:0], 1'b0};
		end
		return nxt;
	endfunction

	// One quotient bit per call; rem stays below den
	function automatic div_t div_step(logic [31:0] rem, logic [31:0] den, logic bin);
		logic [32:0] trial;
		div_t        nxt;
		trial = {rem, bin};
		if (trial >= {1'b0, den}) begin
			nxt.rem  = 32'(trial - {1'b0, den});
			nxt.qbit = 1'b1;
		end else begin
			nxt.rem  = trial[31:0];
			nxt.qbit = 1'b0;
		end
		return nxt;
	endfunction

endpackage

[hw/rtl/amd_rowlen.sv]
// Row lengths and row normalization: squares, sums, pipelined square root,
// pipelined restoring division to Q2.30. Depends on amd_pkg.

module amd_rowlen (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            adv,
	input  logic                            vld,
	input  logic signed [amd_pkg::MAT_W-1:0] mat [9],
	input  amd_pkg::side_t                  side,
	output logic                            nrm_vld,
	output amd_pkg::side_t                  nrm_side,
	output amd_pkg::nrm_t                   nrm [9]
);
	import amd_pkg::*;

	typedef struct packed {
		logic [31:0] rem;
		logic [30:0] low;
		logic [30:0] quo;
		logic        neg;
	} ndiv_t;

	function automatic ndiv_t ndiv_next(ndiv_t cur, logic [31:0] den);
		div_t  s;
		ndiv_t nxt;
		s       = div_step(cur.rem, den, cur.low[30]);
		nxt.rem = s.rem;
		nxt.low = {cur.low[29:0], 1'b0};
		nxt.quo = {cur.quo[29:0], s.qbit};
		nxt.neg = cur.neg;
		return nxt;
	endfunction

	function automatic logic [MAT_W-1:0] row_len(side_t s, int row);
		logic [MAT_W-1:0] l;
		case (row)
			0:       l = s.scale_x;
			1:       l = s.scale_y;
			default: l = s.scale_z;
		endcase
		return l;
	endfunction

	// Stage 1: element squares
	logic signed [47:0]      prod [9];
	logic                    v_s1;
	side_t                   side_s1;
	logic [46:0]             sq_s1 [9];
	logic signed [MAT_W-1:0] m_s1 [9];

	always_comb begin
		for (int e = 0; e < 9; e++) begin
			prod[e] = mat[e] * mat[e];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= vld;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s1 <= side;
			for (int e = 0; e < 9; e++) begin
				m_s1[e]  <= mat[e];
				sq_s1[e] <= prod[e][46:0];
			end
		end
	end

	// Stage 2: sum of squares per row
	logic                    v_s2;
	side_t                   side_s2;
	logic [47:0]             ss_s2 [3];
	logic signed [MAT_W-1:0] m_s2 [9];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s2 <= side_s1;
			m_s2    <= m_s1;
			for (int r = 0; r < 3; r++) begin
				ss_s2[r] <= {1'b0, sq_s1[3*r]} + {1'b0, sq_s1[3*r+1]} + {1'b0, sq_s1[3*r+2]};
			end
		end
	end

	// Square root pipeline, one root bit per stage
	logic                    lv_s   [0:LEN_STEPS];
	side_t                   lside_s [0:LEN_STEPS];
	logic signed [MAT_W-1:0] lm_s   [0:LEN_STEPS][9];
	sqrt_t                   lrt_s  [0:LEN_STEPS][3];
	logic [47:0]             lrad_s [0:LEN_STEPS][3];

	always_comb begin
		lv_s[0]    = v_s2;
		lside_s[0] = side_s2;
		lm_s[0]    = m_s2;
		for (int r = 0; r < 3; r++) begin
			lrt_s[0][r]  = '0;
			lrad_s[0][r] = ss_s2[r];
		end
	end

	for (genvar k = 0; k < LEN_STEPS; k++) begin : g_len
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) lv_s[k+1] <= 1'b0;
			else if (adv) lv_s[k+1] <= lv_s[k];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				lside_s[k+1] <= lside_s[k];
				lm_s[k+1]    <= lm_s[k];
				for (int r = 0; r < 3; r++) begin
					lrt_s[k+1][r]  <= sqrt_step(lrt_s[k][r], lrad_s[k][r][47:46]);
					lrad_s[k+1][r] <= {lrad_s[k][r][45:0], 2'b00};
				end
			end
		end
	end

	// Divider setup: scales, zero flag, magnitudes and dividend tails
	logic [MAT_W-1:0] len [3];
	logic [MAT_W-1:0] mag [9];
	side_t            side_len;

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			len[r] = lrt_s[LEN_STEPS][r].root[MAT_W-1:0];
		end
		side_len         = lside_s[LEN_STEPS];
		side_len.scale_x = len[0];
		side_len.scale_y = len[1];
		side_len.scale_z = len[2];
		side_len.zero    = (len[0] == '0) || (len[1] == '0) || (len[2] == '0);
		for (int e = 0; e < 9; e++) begin
			mag[e] = lm_s[LEN_STEPS][e][MAT_W-1] ? MAT_W'(-lm_s[LEN_STEPS][e])
			                                     : MAT_W'(lm_s[LEN_STEPS][e]);
		end
	end

	logic  dv_s    [0:NRM_STEPS];
	side_t dside_s [0:NRM_STEPS];
	ndiv_t nd_s    [0:NRM_STEPS][9];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dv_s[0] <= 1'b0;
		else if (adv) dv_s[0] <= lv_s[LEN_STEPS];
	end

	// dividend = mag * 2^30 + len/2; top bits seed the remainder
	always_ff @(posedge clk) begin
		if (adv) begin
			dside_s[0] <= side_len;
			for (int e = 0; e < 9; e++) begin
				nd_s[0][e].rem <= 32'(mag[e][MAT_W-1:1]);
				nd_s[0][e].low <= {mag[e][0], 7'b0, len[e/3][MAT_W-1:1]};
				nd_s[0][e].quo <= '0;
				nd_s[0][e].neg <= lm_s[LEN_STEPS][e][MAT_W-1];
			end
		end
	end

	// Division pipeline, one quotient bit per stage
	for (genvar k = 0; k < NRM_STEPS; k++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_s[k+1] <= 1'b0;
			else if (adv) dv_s[k+1] <= dv_s[k];
		end

		always_ff @(posedge clk) begin
			if (adv) dside_s[k+1] <= dside_s[k];
		end

		for (genvar e = 0; e < 9; e++) begin : g_el
			localparam int ROW = e / 3;
			always_ff @(posedge clk) begin
				if (adv) nd_s[k+1][e] <= ndiv_next(nd_s[k][e], 32'(row_len(dside_s[k], ROW)));
			end
		end
	end

	// Signed normalized elements
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) nrm_vld <= 1'b0;
		else if (adv) nrm_vld <= dv_s[NRM_STEPS];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			nrm_side <= dside_s[NRM_STEPS];
			for (int e = 0; e < 9; e++) begin
				nrm[e] <= nd_s[NRM_STEPS][e].neg ? -NRM_W'(nd_s[NRM_STEPS][e].quo)
				                                 : NRM_W'(nd_s[NRM_STEPS][e].quo);
			end
		end
	end

endmodule

[hw/rtl/amd_quat.sv]
// Quaternion from the normalized 3x3 rows: branch choice, pipelined square
// root, three pipelined dividers, clamping and assembly. Depends on amd_pkg.

module amd_quat (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             adv,
	input  logic                             vld,
	input  amd_pkg::side_t                   side,
	input  amd_pkg::nrm_t                    nrm [9],
	output logic                             res_vld,
	output amd_pkg::side_t                   res_side,
	output logic signed [amd_pkg::QUAT_W-1:0] qw,
	output logic signed [amd_pkg::QUAT_W-1:0] qx,
	output logic signed [amd_pkg::QUAT_W-1:0] qy,
	output logic signed [amd_pkg::QUAT_W-1:0] qz
);
	import amd_pkg::*;

	// Items carried alongside the root and divider pipelines
	typedef struct packed {
		side_t              side;
		branch_t            big;
		logic               deg;
		logic signed [32:0] num0;
		logic signed [32:0] num1;
		logic signed [32:0] num2;
	} qctl_t;

	typedef struct packed {
		logic [31:0] rem;
		logic [16:0] low;
		logic [16:0] quo;
		logic        ovf;
		logic        neg;
	} qdiv_t;

	function automatic qdiv_t qdiv_next(qdiv_t cur, logic [31:0] den);
		div_t  s;
		qdiv_t nxt;
		s       = div_step(cur.rem, den, cur.low[16]);
		nxt.rem = s.rem;
		nxt.low = {cur.low[15:0], 1'b0};
		nxt.quo = {cur.quo[15:0], s.qbit};
		nxt.ovf = cur.ovf;
		nxt.neg = cur.neg;
		return nxt;
	endfunction

	function automatic logic signed [QUAT_W-1:0] qfinal(qdiv_t c);
		logic [16:0] m;
		m = (c.ovf || (c.quo > QUAT_ONE)) ? QUAT_ONE : c.quo;
		return c.neg ? -QUAT_W'(m) : QUAT_W'(m);
	endfunction

	// Stage 1: trace and diagonal compares
	logic               v_s1;
	side_t              side_s1;
	nrm_t               r_s1 [9];
	logic signed [34:0] t_s1;
	logic               c01_s1, c02_s1, c12_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= vld;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s1 <= side;
			r_s1    <= nrm;
			t_s1    <= 35'(nrm[0]) + 35'(nrm[4]) + 35'(nrm[8]);
			c01_s1  <= nrm[0] > nrm[4];
			c02_s1  <= nrm[0] > nrm[8];
			c12_s1  <= nrm[4] > nrm[8];
		end
	end

	// Stage 2: branch, radicand and numerators
	branch_t            big_c;
	logic signed [34:0] d_c;
	logic signed [32:0] n0_c, n1_c, n2_c;
	logic signed [32:0] a12m, a20m, a01m, a01p, a02p, a12p;
	logic signed [34:0] r00, r11, r22;

	always_comb begin
		r00  = 35'(r_s1[0]);
		r11  = 35'(r_s1[4]);
		r22  = 35'(r_s1[8]);
		a12m = 33'(r_s1[5]) - 33'(r_s1[7]);
		a20m = 33'(r_s1[6]) - 33'(r_s1[2]);
		a01m = 33'(r_s1[1]) - 33'(r_s1[3]);
		a01p = 33'(r_s1[1]) + 33'(r_s1[3]);
		a02p = 33'(r_s1[2]) + 33'(r_s1[6]);
		a12p = 33'(r_s1[5]) + 33'(r_s1[7]);
		if (t_s1 > 0)             big_c = BR_W;
		else if (c01_s1 && c02_s1) big_c = BR_X;
		else if (c12_s1)          big_c = BR_Y;
		else                      big_c = BR_Z;
		unique case (big_c)
			BR_W: begin
				d_c = NRM_ONE + t_s1;
				n0_c = a12m; n1_c = a20m; n2_c = a01m;
			end
			BR_X: begin
				d_c = NRM_ONE + r00 - r11 - r22;
				n0_c = a12m; n1_c = a01p; n2_c = a02p;
			end
			BR_Y: begin
				d_c = NRM_ONE + r11 - r00 - r22;
				n0_c = a20m; n1_c = a01p; n2_c = a12p;
			end
			default: begin
				d_c = NRM_ONE + r22 - r00 - r11;
				n0_c = a01m; n1_c = a02p; n2_c = a12p;
			end
		endcase
	end

	logic               v_s2;
	qctl_t              ctl_s2;
	logic signed [34:0] d_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s2.side <= side_s1;
			ctl_s2.big  <= big_c;
			ctl_s2.deg  <= (d_c <= 0);
			ctl_s2.num0 <= n0_c;
			ctl_s2.num1 <= n1_c;
			ctl_s2.num2 <= n2_c;
			d_s2        <= d_c;
		end
	end

	// Square root of d in Q.30, one root bit per stage
	logic        rv_s   [0:ROOT_STEPS];
	qctl_t       rctl_s [0:ROOT_STEPS];
	sqrt_t       rrt_s  [0:ROOT_STEPS];
	logic [63:0] rrad_s [0:ROOT_STEPS];

	always_comb begin
		rv_s[0]   = v_s2;
		rctl_s[0] = ctl_s2;
		rrt_s[0]  = '0;
		rrad_s[0] = ctl_s2.deg ? 64'd0 : {1'b0, d_s2[32:0], 30'b0};
	end

	for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) rv_s[k+1] <= 1'b0;
			else if (adv) rv_s[k+1] <= rv_s[k];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rctl_s[k+1] <= rctl_s[k];
				rrt_s[k+1]  <= sqrt_step(rrt_s[k], rrad_s[k][63:62]);
				rrad_s[k+1] <= {rrad_s[k][61:0], 2'b00};
			end
		end
	end

	// Divider setup: dividend = |num| * 2^15 + root/2, overflow when quotient >= 2^17
	logic [31:0]        root;
	logic signed [32:0] numv [3];
	logic [31:0]        nmag [3];
	logic [46:0]        nn   [3];
	logic [32:0]        bsum;
	logic [16:0]        bigq;

	always_comb begin
		root    = rrt_s[ROOT_STEPS].root;
		numv[0] = rctl_s[ROOT_STEPS].num0;
		numv[1] = rctl_s[ROOT_STEPS].num1;
		numv[2] = rctl_s[ROOT_STEPS].num2;
		for (int j = 0; j < 3; j++) begin
			nmag[j] = numv[j][32] ? 32'(-numv[j]) : 32'(numv[j]);
			nn[j]   = {nmag[j], 15'b0} + 47'(root[31:1]);
		end
		bsum = {1'b0, root} + 33'd16384;
		bigq = (bsum[32:15] > 18'(QUAT_ONE)) ? QUAT_ONE : bsum[31:15];
	end

	logic        qv_s    [0:QDIV_STEPS];
	qctl_t       qctl_s  [0:QDIV_STEPS];
	logic [31:0] qroot_s [0:QDIV_STEPS];
	logic [16:0] qbig_s  [0:QDIV_STEPS];
	qdiv_t       qd_s    [0:QDIV_STEPS][3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) qv_s[0] <= 1'b0;
		else if (adv) qv_s[0] <= rv_s[ROOT_STEPS];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			qctl_s[0]  <= rctl_s[ROOT_STEPS];
			qroot_s[0] <= root;
			qbig_s[0]  <= bigq;
			for (int j = 0; j < 3; j++) begin
				qd_s[0][j].rem <= {2'b00, nn[j][46:17]};
				qd_s[0][j].low <= nn[j][16:0];
				qd_s[0][j].quo <= '0;
				qd_s[0][j].ovf <= {2'b00, nn[j][46:17]} >= root;
				qd_s[0][j].neg <= numv[j][32];
			end
		end
	end

	// Division pipeline, one quotient bit per stage
	for (genvar k = 0; k < QDIV_STEPS; k++) begin : g_qdiv
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) qv_s[k+1] <= 1'b0;
			else if (adv) qv_s[k+1] <= qv_s[k];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				qctl_s[k+1]  <= qctl_s[k];
				qroot_s[k+1] <= qroot_s[k];
				qbig_s[k+1]  <= qbig_s[k];
				for (int j = 0; j < 3; j++) begin
					qd_s[k+1][j] <= qdiv_next(qd_s[k][j], qroot_s[k]);
				end
			end
		end
	end

	// Clamp, sign and place the components; identity for degenerate input
	qctl_t                     fctl;
	logic signed [QUAT_W-1:0]  c0, c1, c2, cb;
	logic signed [QUAT_W-1:0]  w_c, x_c, y_c, z_c;

	always_comb begin
		fctl = qctl_s[QDIV_STEPS];
		c0   = qfinal(qd_s[QDIV_STEPS][0]);
		c1   = qfinal(qd_s[QDIV_STEPS][1]);
		c2   = qfinal(qd_s[QDIV_STEPS][2]);
		cb   = QUAT_W'(qbig_s[QDIV_STEPS]);
		unique case (fctl.big)
			BR_W:    begin w_c = cb; x_c = c0; y_c = c1; z_c = c2; end
			BR_X:    begin w_c = c0; x_c = cb; y_c = c1; z_c = c2; end
			BR_Y:    begin w_c = c0; x_c = c1; y_c = cb; z_c = c2; end
			default: begin w_c = c0; x_c = c1; y_c = c2; z_c = cb; end
		endcase
		if (fctl.side.zero || fctl.deg) begin
			w_c = QUAT_W'(QUAT_ONE);
			x_c = '0;
			y_c = '0;
			z_c = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) res_vld <= 1'b0;
		else if (adv) res_vld <= qv_s[QDIV_STEPS];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_side <= fctl.side;
			qw       <= w_c;
			qx       <= x_c;
			qy       <= y_c;
			qz       <= z_c;
		end
	end

endmodule

[hw/rtl/affine_matrix_decompose.sv]
// Top level of the affine matrix decomposer (position, row scales, quaternion).
// Depends on amd_pkg, amd_rowlen and amd_quat.
//
// Usage:
//   Input channel mat_valid/mat_ready carries one beat per matrix: the 3x3
//   part m00..m22 and the translation tx, ty, tz, all signed Q8.16.
//   Output channel res_valid/res_ready carries one beat per matrix: pos_x..z,
//   scale_x..z (row lengths, unsigned Q8.16), quat_w..z (signed Q1.16) and
//   zero_scale, which flags a zero row and forces the identity quaternion.
//   Throughput is one matrix per cycle while res_ready keeps the pipeline
//   moving; the depth comes from the two bit-per-stage square roots (24 and
//   32 stages) and the two bit-per-stage divider banks (31 and 17 stages),
//   each stage one compare and subtract. All stages move together: when a
//   result waits with res_ready low, the pipeline holds and mat_ready drops,
//   so nothing is lost or repeated. Bubbles travel as empty stages. Reset
//   clears every stage valid bit; the block can take a beat as soon as reset
//   is released.

module affine_matrix_decompose (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                mat_valid,
	output logic                mat_ready,
	input  logic signed [23:0]  m00,
	input  logic signed [23:0]  m01,
	input  logic signed [23:0]  m02,
	input  logic signed [23:0]  m10,
	input  logic signed [23:0]  m11,
	input  logic signed [23:0]  m12,
	input  logic signed [23:0]  m20,
	input  logic signed [23:0]  m21,
	input  logic signed [23:0]  m22,
	input  logic signed [23:0]  tx,
	input  logic signed [23:0]  ty,
	input  logic signed [23:0]  tz,
	output logic                res_valid,
	input  logic                res_ready,
	output logic signed [23:0]  pos_x,
	output logic signed [23:0]  pos_y,
	output logic signed [23:0]  pos_z,
	output logic [23:0]         scale_x,
	output logic [23:0]         scale_y,
	output logic [23:0]         scale_z,
	output logic signed [17:0]  quat_w,
	output logic signed [17:0]  quat_x,
	output logic signed [17:0]  quat_y,
	output logic signed [17:0]  quat_z,
	output logic                zero_scale
);
	import amd_pkg::*;

	logic                    adv;
	logic signed [MAT_W-1:0] mat [9];
	side_t                   side_in;
	logic                    nrm_vld;
	side_t                   nrm_side;
	nrm_t                    nrm [9];
	side_t                   res_side;

	// Global advance: the output register frees when its beat is taken
	assign adv       = !res_valid || res_ready;
	assign mat_ready = adv;

	assign mat[0] = m00;
	assign mat[1] = m01;
	assign mat[2] = m02;
	assign mat[3] = m10;
	assign mat[4] = m11;
	assign mat[5] = m12;
	assign mat[6] = m20;
	assign mat[7] = m21;
	assign mat[8] = m22;

	always_comb begin
		side_in         = '0;
		side_in.pos_x   = tx;
		side_in.pos_y   = ty;
		side_in.pos_z   = tz;
	end

	amd_rowlen u_rowlen (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.vld      (mat_valid),
		.mat      (mat),
		.side     (side_in),
		.nrm_vld  (nrm_vld),
		.nrm_side (nrm_side),
		.nrm      (nrm)
	);

	amd_quat u_quat (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.vld      (nrm_vld),
		.side     (nrm_side),
		.nrm      (nrm),
		.res_vld  (res_valid),
		.res_side (res_side),
		.qw       (quat_w),
		.qx       (quat_x),
		.qy       (quat_y),
		.qz       (quat_z)
	);

	assign pos_x      = res_side.pos_x;
	assign pos_y      = res_side.pos_y;
	assign pos_z      = res_side.pos_z;
	assign scale_x    = res_side.scale_x;
	assign scale_y    = res_side.scale_y;
	assign scale_z    = res_side.scale_z;
	assign zero_scale = res_side.zero;

endmodule

[tb/testbench.sv]
// Self-checking bench for affine_matrix_decompose: position, row scales, quaternion.
// Depends on amd_pkg (branch_t) and the affine_matrix_decompose RTL only.

module testbench;
	import amd_pkg::*;

	typedef struct {
		logic signed [23:0] m [9];
		logic signed [23:0] t [3];
	} mat_beat_t;

	typedef struct {
		logic signed [23:0] pos [3];
		logic [23:0]        scl [3];
		logic signed [17:0] q [4];
		logic               zero;
	} trs_t;

	localparam longint ONE30 = 64'sd1 << 30;
	localparam longint QONE  = 64'sd65536;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic mat_valid = 1'b0;
	logic res_ready = 1'b0;
	logic signed [23:0] m00 = '0, m01 = '0, m02 = '0, m10 = '0, m11 = '0, m12 = '0;
	logic signed [23:0] m20 = '0, m21 = '0, m22 = '0, tx = '0, ty = '0, tz = '0;
	logic mat_ready, res_valid, zero_scale;
	logic signed [23:0] pos_x, pos_y, pos_z;
	logic [23:0] scale_x, scale_y, scale_z;
	logic signed [17:0] quat_w, quat_x, quat_y, quat_z;

	trs_t expected_trs [$];
	int   errors = 0;
	bit   idle_on = 1'b1;

	affine_matrix_decompose dut (.*);

	always #5 clk = ~clk;

	// integer square root, floor
	function automatic longint unsigned isqrt(longint unsigned v);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else
				res >>= 1;
			b >>= 2;
		end
		return res;
	endfunction

	// division rounded half away from zero, den > 0
	function automatic longint rnd_div(longint num, longint den);
		longint unsigned mag, qt;
		mag = (num < 0) ? -num : num;
		qt = (mag + den / 2) / den;
		return (num < 0) ? -longint'(qt) : longint'(qt);
	endfunction

	function automatic longint clamp_q(longint v);
		return (v > QONE) ? QONE : (v < -QONE) ? -QONE : v;
	endfunction

	function automatic trs_t decompose(mat_beat_t b);
		trs_t    o;
		longint  r [3][3];
		longint  len [3];
		longint  n [4];
		longint  qv [4];
		longint  tr, d, root, v;
		longint unsigned ss;
		branch_t big;
		qv = '{QONE, 0, 0, 0};
		o.zero = 1'b0;
		for (int i = 0; i < 3; i++) begin
			ss = 0;
			for (int j = 0; j < 3; j++)
				ss += longint'(b.m[i*3+j]) * longint'(b.m[i*3+j]);
			len[i] = isqrt(ss);
			if (len[i] > 64'hFFFFFF) len[i] = 64'hFFFFFF;
			if (len[i] == 0) o.zero = 1'b1;
			o.scl[i] = len[i][23:0];
			o.pos[i] = b.t[i];
		end
		if (!o.zero) begin
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++) begin
					v = rnd_div(longint'(b.m[i*3+j]) * ONE30, len[i]);
					r[i][j] = (v > ONE30) ? ONE30 : (v < -ONE30) ? -ONE30 : v;
				end
			tr = r[0][0] + r[1][1] + r[2][2];
			if (tr > 0) begin
				big = BR_W;
				d = ONE30 + tr;
				n[1] = r[1][2] - r[2][1];
				n[2] = r[2][0] - r[0][2];
				n[3] = r[0][1] - r[1][0];
			end else if (r[0][0] > r[1][1] && r[0][0] > r[2][2]) begin
				big = BR_X;
				d = ONE30 + r[0][0] - r[1][1] - r[2][2];
				n[0] = r[1][2] - r[2][1];
				n[2] = r[0][1] + r[1][0];
				n[3] = r[0][2] + r[2][0];
			end else if (r[1][1] > r[2][2]) begin
				big = BR_Y;
				d = ONE30 + r[1][1] - r[0][0] - r[2][2];
				n[0] = r[2][0] - r[0][2];
				n[1] = r[0][1] + r[1][0];
				n[3] = r[1][2] + r[2][1];
			end else begin
				big = BR_Z;
				d = ONE30 + r[2][2] - r[0][0] - r[1][1];
				n[0] = r[0][1] - r[1][0];
				n[1] = r[0][2] + r[2][0];
				n[2] = r[1][2] + r[2][1];
			end
			if (d > 0) begin
				root = isqrt(longint'(d) << 30);
				if (root > 0)
					for (int i = 0; i < 4; i++)
						qv[i] = (i == int'(big)) ? clamp_q((root + (64'sd1 << 14)) >>> 15)
							: clamp_q(rnd_div(n[i] * 32768, root));
			end
		end
		for (int i = 0; i < 4; i++) o.q[i] = qv[i][17:0];
		return o;
	endfunction

	// Drive one beat, hold until accepted; valid drops only while idling
	task automatic send_mat(mat_beat_t b);
		while (idle_on && $urandom_range(99) < 33) begin
			mat_valid <= 1'b0;
			@(negedge clk);
		end
		{m00, m01, m02, m10, m11, m12, m20, m21, m22} <=
			{b.m[0], b.m[1], b.m[2], b.m[3], b.m[4], b.m[5], b.m[6], b.m[7], b.m[8]};
		{tx, ty, tz} <= {b.t[0], b.t[1], b.t[2]};
		mat_valid <= 1'b1;
		do @(posedge clk); while (!mat_ready);
		expected_trs.push_back(decompose(b));
		@(negedge clk);
	endtask

	function automatic mat_beat_t rnd_noise();
		mat_beat_t b;
		for (int i = 0; i < 9; i++) b.m[i] = 24'($urandom);
		for (int i = 0; i < 3; i++) b.t[i] = 24'($urandom);
		return b;
	endfunction

	// Scaled near-rotation: signed permutation times row scales plus jitter
	function automatic mat_beat_t rnd_rotlike();
		mat_beat_t b;
		int perm [3];
		int k, s, j;
		longint v;
		perm = '{0, 1, 2};
		perm.shuffle();
		for (int i = 0; i < 3; i++) begin
			s = $urandom_range(3) == 0 ? $urandom_range(100, 4000) : $urandom_range(1, 300000);
			for (j = 0; j < 3; j++) begin
				v = (j == perm[i]) ? s : 0;
				if ($urandom_range(1)) v = -v;
				v += $signed($urandom_range(s / 2)) - s / 4;
				b.m[i*3+j] = v[23:0];
			end
		end
		for (k = 0; k < 3; k++) b.t[k] = 24'($urandom);
		return b;
	endfunction

	task automatic drain();
		mat_valid <= 1'b0;
		while (expected_trs.size() != 0) @(negedge clk);
	endtask

	task automatic test_directed();
		mat_beat_t b;
		logic signed [23:0] ext [4];
		ext = '{24'sh7FFFFF, -24'sh800000, 24'sd0, 24'sd65536};
		// identity, then max, min, zero and one in every element
		foreach (b.m[i]) b.m[i] = 0;
		b.m[0] = 65536; b.m[4] = 65536; b.m[8] = 65536;
		b.t = '{24'sh7FFFFF, -24'sh800000, 24'sd1};
		send_mat(b);
		foreach (ext[k]) begin
			foreach (b.m[i]) b.m[i] = ext[k];
			b.t = '{ext[k], ext[k], ext[k]};
			send_mat(b);
		end
		// one zero row
		b = rnd_rotlike();
		b.m[3] = 0; b.m[4] = 0; b.m[5] = 0;
		send_mat(b);
		// x, y and z branches: half turns about each axis
		for (int a = 0; a < 3; a++) begin
			foreach (b.m[i]) b.m[i] = 0;
			for (int i = 0; i < 3; i++) b.m[i*4] = (i == a) ? 65536 : -65536;
			send_mat(b);
		end
		// all-negative diagonal with ties: falls through to the z branch
		foreach (b.m[i]) b.m[i] = 0;
		b.m[0] = -65536; b.m[4] = -65536; b.m[8] = -65536;
		send_mat(b);
		// max row length, minimum magnitude values
		foreach (b.m[i]) b.m[i] = -24'sh800000;
		b.m[1] = 1; b.m[5] = -1;
		send_mat(b);
		foreach (b.m[i]) b.m[i] = (i % 4 == 0) ? 1 : 0;
		send_mat(b);
		// pause until everything came back
		drain();
	endtask

	task automatic test_random(int count);
		for (int n = 0; n < count; n++) begin
			idle_on = !(n >= 300 && n < 450);
			send_mat(($urandom_range(9) < 7) ? rnd_rotlike() : rnd_noise());
		end
		idle_on = 1'b1;
	endtask

	// Result side: random stalls, checked against oldest expectation
	always @(negedge clk)
		res_ready <= arst_n && (!idle_on || $urandom_range(99) >= 33);

	always @(posedge clk) begin
		trs_t e;
		if (arst_n && res_valid && res_ready) begin
			if (expected_trs.size() == 0) begin
				$error("result beat with nothing expected");
				errors++;
			end else begin
				e = expected_trs.pop_front();
				if (pos_x !== e.pos[0]) begin $error("pos_x exp %0d got %0d", e.pos[0], pos_x); errors++; end
				if (pos_y !== e.pos[1]) begin $error("pos_y exp %0d got %0d", e.pos[1], pos_y); errors++; end
				if (pos_z !== e.pos[2]) begin $error("pos_z exp %0d got %0d", e.pos[2], pos_z); errors++; end
				if (scale_x !== e.scl[0]) begin $error("scale_x exp %0d got %0d", e.scl[0], scale_x); errors++; end
				if (scale_y !== e.scl[1]) begin $error("scale_y exp %0d got %0d", e.scl[1], scale_y); errors++; end
				if (scale_z !== e.scl[2]) begin $error("scale_z exp %0d got %0d", e.scl[2], scale_z); errors++; end
				if (quat_w !== e.q[0]) begin $error("quat_w exp %0d got %0d", e.q[0], quat_w); errors++; end
				if (quat_x !== e.q[1]) begin $error("quat_x exp %0d got %0d", e.q[1], quat_x); errors++; end
				if (quat_y !== e.q[2]) begin $error("quat_y exp %0d got %0d", e.q[2], quat_y); errors++; end
				if (quat_z !== e.q[3]) begin $error("quat_z exp %0d got %0d", e.q[3], quat_z); errors++; end
				if (zero_scale !== e.zero) begin
					$error("zero_scale exp %0b got %0b", e.zero, zero_scale);
					errors++;
				end
			end
		end
	end

	initial begin
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_random(1040);
		drain();
		repeat (150) @(negedge clk);
		if (errors == 0 && expected_trs.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// Watchdog
	initial begin
		#2000000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
